FILE: rtl/core/bpm_pkg.sv
// shared types, codes and helpers for the bracket pair matcher
`timescale 1ns / 1ps

package bpm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned POS_W           = 32;
  localparam int unsigned KIND_W          = 2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_e_t;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_IF    = 2'd2,
    KIND_ENDIF = 2'd3
  } kind_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SCAN_START,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  sp_start;
    logic [POS_W-1:0]  sp_end;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic append;
    logic query_start;
    logic srch_rd;
    logic srch_eval;
    logic scan_init;
    logic scan_issue;
    logic scan_eval;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lo_lt_hi;
    logic hit_flag;
    logic strict_hit;
    logic scan_none;
    logic scan_last;
    logic match;
  } status_t;

  function automatic logic is_opener(input logic [KIND_W-1:0] kind);
    return (kind_e_t'(kind) == KIND_OPEN) || (kind_e_t'(kind) == KIND_IF);
  endfunction

endpackage

FILE: rtl/core/bpm_ctrl.sv
// control state machine for the bracket pair matcher
`timescale 1ns / 1ps

module bpm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  output logic               out_valid,
  input  logic               out_ready,
  input  bpm_pkg::status_t   st,
  output bpm_pkg::cmd_t      cmd
);

  bpm_pkg::state_t state_r, state_nxt;
  logic more_r, more_nxt;
  logic pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpm_pkg::ST_IDLE;
      more_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      more_r      <= more_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    more_nxt  = more_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      bpm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        more_nxt = 1'b0;
        pend_nxt = 1'b0;
        if (in_valid) begin
          unique case (bpm_pkg::opcode_e_t'(in_opcode))
            bpm_pkg::OP_CLEAR:  cmd.clear = 1'b1;
            bpm_pkg::OP_APPEND: cmd.append = 1'b1;
            bpm_pkg::OP_QUERY: begin
              cmd.query_start = 1'b1;
              state_nxt       = bpm_pkg::ST_SRCH_RD;
            end
            default: ;
          endcase
        end
      end
      bpm_pkg::ST_SRCH_RD: begin
        if (st.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = bpm_pkg::ST_SRCH_CMP;
        end else if (st.hit_flag) begin
          state_nxt = bpm_pkg::ST_SCAN_START;
        end else begin
          state_nxt = bpm_pkg::ST_FINISH;
        end
      end
      bpm_pkg::ST_SRCH_CMP: begin
        cmd.srch_eval = 1'b1;
        state_nxt     = st.strict_hit ? bpm_pkg::ST_SCAN_START : bpm_pkg::ST_SRCH_RD;
      end
      bpm_pkg::ST_SCAN_START: begin
        if (st.scan_none) begin
          state_nxt = bpm_pkg::ST_FINISH;
        end else begin
          cmd.scan_init = 1'b1;
          more_nxt      = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = bpm_pkg::ST_SCAN;
        end
      end
      bpm_pkg::ST_SCAN: begin
        cmd.scan_issue = more_r;
        cmd.scan_eval  = pend_r;
        pend_nxt       = more_r;
        more_nxt       = more_r && !st.scan_last;
        if ((pend_r && st.match) || (!more_r && !pend_r)) begin
          state_nxt = bpm_pkg::ST_FINISH;
        end
      end
      bpm_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = bpm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/bpm_dp.sv
// span table, binary search and nesting scan datapath for the bracket pair matcher
`timescale 1ns / 1ps

module bpm_dp #(
  parameter int unsigned TABLE_DEPTH = bpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpm_pkg::cmd_t                 cmd,
  output bpm_pkg::status_t              st,
  input  logic [bpm_pkg::KIND_W-1:0]    in_token_kind,
  input  logic [bpm_pkg::POS_W-1:0]     in_token_start,
  input  logic [bpm_pkg::POS_W-1:0]     in_token_end,
  input  logic [bpm_pkg::POS_W-1:0]     in_cursor_position,
  output logic                          out_hit,
  output logic [bpm_pkg::POS_W-1:0]     out_hit_start,
  output logic [bpm_pkg::POS_W-1:0]     out_hit_end,
  output logic                          out_partner_found,
  output logic [bpm_pkg::POS_W-1:0]     out_partner_start,
  output logic [bpm_pkg::POS_W-1:0]     out_partner_end
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  bpm_pkg::entry_t mem [TABLE_DEPTH];
  bpm_pkg::entry_t rd_q_r;

  logic [CW-1:0]  count_r;
  logic [CW-1:0]  lo_r, hi_r, pend_idx_r, hit_idx_r, scan_next_r, depth_r;
  logic [CW:0]    mid_sum;
  logic [CW-1:0]  mid;
  logic [CW:0]    hit_inc;
  logic [bpm_pkg::POS_W-1:0]  pos_r;
  logic [bpm_pkg::KIND_W-1:0] hit_kind_r;
  logic [bpm_pkg::POS_W-1:0]  hit_start_r, hit_end_r, part_start_r, part_end_r;
  logic hit_flag_r, part_flag_r;
  logic full, hit_open, lt, gt, eq_end, deepen;
  logic [AW-1:0]  rd_addr;

  assign full     = (count_r == DEPTH_C);
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CW:1];
  assign rd_addr  = cmd.srch_rd ? mid[AW-1:0] : scan_next_r[AW-1:0];
  assign hit_open = bpm_pkg::is_opener(hit_kind_r);
  assign hit_inc  = {1'b0, hit_idx_r} + {1'b0, ONE_C};
  assign lt       = pos_r < rd_q_r.sp_start;
  assign gt       = pos_r > rd_q_r.sp_end;
  assign eq_end   = pos_r == rd_q_r.sp_end;
  assign deepen   = (bpm_pkg::is_opener(rd_q_r.kind) == hit_open);

  assign st.lo_lt_hi   = lo_r < hi_r;
  assign st.hit_flag   = hit_flag_r;
  assign st.strict_hit = !lt && !gt && !eq_end;
  assign st.scan_none  = hit_open ? (hit_inc >= {1'b0, count_r}) : (hit_idx_r == '0);
  assign st.scan_last  = hit_open ? (scan_next_r == count_r - ONE_C) : (scan_next_r == '0);
  assign st.match      = !deepen && (depth_r == ONE_C);

  // table memory
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[count_r[AW-1:0]] <= '{kind: in_token_kind, sp_start: in_token_start,
                                sp_end: in_token_end};
    end
    if (cmd.srch_rd || cmd.scan_issue) begin
      rd_q_r     <= mem[rd_addr];
      pend_idx_r <= cmd.srch_rd ? mid : scan_next_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append && !full) begin
      count_r <= count_r + ONE_C;
    end
  end

  // search and scan registers
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      pos_r        <= in_cursor_position;
      lo_r         <= '0;
      hi_r         <= count_r;
      hit_flag_r   <= 1'b0;
      part_flag_r  <= 1'b0;
      hit_start_r  <= '0;
      hit_end_r    <= '0;
      part_start_r <= '0;
      part_end_r   <= '0;
    end
    if (cmd.srch_eval) begin
      if (lt) begin
        hi_r <= pend_idx_r;
      end else if (gt) begin
        lo_r <= pend_idx_r + ONE_C;
      end else begin
        if (eq_end) begin
          lo_r <= pend_idx_r + ONE_C;
        end
        hit_flag_r  <= 1'b1;
        hit_idx_r   <= pend_idx_r;
        hit_kind_r  <= rd_q_r.kind;
        hit_start_r <= rd_q_r.sp_start;
        hit_end_r   <= rd_q_r.sp_end;
      end
    end
    if (cmd.scan_init) begin
      scan_next_r <= hit_open ? hit_inc[CW-1:0] : hit_idx_r - ONE_C;
      depth_r     <= ONE_C;
    end else if (cmd.scan_issue) begin
      scan_next_r <= hit_open ? scan_next_r + ONE_C : scan_next_r - ONE_C;
    end
    if (cmd.scan_eval) begin
      if (deepen) begin
        depth_r <= depth_r + ONE_C;
      end else if (depth_r == ONE_C) begin
        part_flag_r  <= 1'b1;
        part_start_r <= rd_q_r.sp_start;
        part_end_r   <= rd_q_r.sp_end;
      end else begin
        depth_r <= depth_r - ONE_C;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit           <= hit_flag_r;
      out_hit_start     <= hit_start_r;
      out_hit_end       <= hit_end_r;
      out_partner_found <= part_flag_r;
      out_partner_start <= part_start_r;
      out_partner_end   <= part_end_r;
    end
  end

endmodule

FILE: rtl/core/bracket_pair_matcher.sv
// Bracket pair matcher: keeps a table of bracket and block tokens in a single-port span
// memory and, for a cursor query, finds the token under the cursor by binary search and
// its partner by a nesting-depth scan. Clear and append words are handled in the idle
// state. A query runs search steps that each read a table entry and then compare it, a
// closing search check unless a strict hit ends the search, and the scan set-up; the scan
// then reads one table entry per cycle through the memory's single read port, and the
// result is then handed off to the output. One query is in flight at a time; clear and
// append words are still taken while a finished result waits on the output.
`timescale 1ns / 1ps

module bracket_pair_matcher #(
  parameter int unsigned TABLE_DEPTH = bpm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [bpm_pkg::KIND_W-1:0] in_token_kind,
  input  logic [bpm_pkg::POS_W-1:0]  in_token_start,
  input  logic [bpm_pkg::POS_W-1:0]  in_token_end,
  input  logic [bpm_pkg::POS_W-1:0]  in_cursor_position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [bpm_pkg::POS_W-1:0]  out_hit_start,
  output logic [bpm_pkg::POS_W-1:0]  out_hit_end,
  output logic                       out_partner_found,
  output logic [bpm_pkg::POS_W-1:0]  out_partner_start,
  output logic [bpm_pkg::POS_W-1:0]  out_partner_end
);

  bpm_pkg::cmd_t    cmd;
  bpm_pkg::status_t st;

  bpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  bpm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_token_kind      (in_token_kind),
    .in_token_start     (in_token_start),
    .in_token_end       (in_token_end),
    .in_cursor_position (in_cursor_position),
    .out_hit            (out_hit),
    .out_hit_start      (out_hit_start),
    .out_hit_end        (out_hit_end),
    .out_partner_found  (out_partner_found),
    .out_partner_start  (out_partner_start),
    .out_partner_end    (out_partner_end)
  );

  // a query occupies the block until its result is handed off
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == bpm_pkg::OP_QUERY) |=> !in_ready)
    else $error("query accepted but block still ready");

  // search compare uses the read issued the cycle before
  a_srch_rd_lat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_eval |-> $past(cmd.srch_rd))
    else $error("search compare without preceding read");

  // scan evaluation uses the read issued the cycle before
  a_scan_rd_lat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_eval |-> $past(cmd.scan_issue))
    else $error("scan evaluate without preceding read");

  // a loaded result is presented on the next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not presented");

endmodule

FILE: tb/bpm_checker.sv
// checker for the bracket pair matcher: predicts each query result and compares it
`timescale 1ns / 1ps

module bpm_checker
  import bpm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [KIND_W-1:0] in_token_kind,
  input  logic [POS_W-1:0]  in_token_start,
  input  logic [POS_W-1:0]  in_token_end,
  input  logic [POS_W-1:0]  in_cursor_position,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_hit,
  input  logic [POS_W-1:0]  out_hit_start,
  input  logic [POS_W-1:0]  out_hit_end,
  input  logic              out_partner_found,
  input  logic [POS_W-1:0]  out_partner_start,
  input  logic [POS_W-1:0]  out_partner_end,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] hit_start;
    logic [POS_W-1:0] hit_end;
    logic             partner_found;
    logic [POS_W-1:0] partner_start;
    logic [POS_W-1:0] partner_end;
  } match_t;

  logic [POS_W-1:0] span_lo   [TABLE_DEPTH];
  logic [POS_W-1:0] span_hi   [TABLE_DEPTH];
  kind_e_t          span_kind [TABLE_DEPTH];
  int unsigned      n_spans;
  match_t           expected_matches[$];

  function automatic bit is_open_side(input kind_e_t k);
    return (k == KIND_OPEN) || (k == KIND_IF);
  endfunction

  function automatic match_t locate_partner(input logic [POS_W-1:0] cursor);
    match_t      m;
    int unsigned lo, hi, mid, fallback, h, i, p, depth;
    bit          has_fallback, has_hit, found;
    m            = '0;
    lo           = 0;
    hi           = n_spans;
    fallback     = 0;
    h            = 0;
    p            = 0;
    has_fallback = 1'b0;
    has_hit      = 1'b0;
    found        = 1'b0;
    while ((lo < hi) && !has_hit) begin
      mid = (lo + hi) / 2;
      if (cursor < span_lo[mid]) begin
        hi = mid;
      end else if (cursor > span_hi[mid]) begin
        lo = mid + 1;
      end else if (cursor == span_hi[mid]) begin
        fallback     = mid;
        has_fallback = 1'b1;
        lo           = mid + 1;
      end else begin
        h       = mid;
        has_hit = 1'b1;
      end
    end
    if (!has_hit && has_fallback) begin
      h       = fallback;
      has_hit = 1'b1;
    end
    if (!has_hit) return m;
    m.hit       = 1'b1;
    m.hit_start = span_lo[h];
    m.hit_end   = span_hi[h];
    depth = 1;
    if (is_open_side(span_kind[h])) begin
      for (i = h + 1; (i < n_spans) && !found; i++) begin
        if (is_open_side(span_kind[i])) begin
          depth++;
        end else begin
          depth--;
          if (depth == 0) begin
            found = 1'b1;
            p     = i;
          end
        end
      end
    end else begin
      for (i = h; (i > 0) && !found; i--) begin
        if (!is_open_side(span_kind[i-1])) begin
          depth++;
        end else begin
          depth--;
          if (depth == 0) begin
            found = 1'b1;
            p     = i - 1;
          end
        end
      end
    end
    if (found) begin
      m.partner_found = 1'b1;
      m.partner_start = span_lo[p];
      m.partner_end   = span_hi[p];
    end
    return m;
  endfunction

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    match_t want;
    if (!rst_n) begin
      n_spans = 0;
      expected_matches.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_matches.size() == 0) begin
          $error("result word with no query waiting");
          fail_count++;
        end else begin
          want = expected_matches.pop_front();
          check_field("hit", want.hit, out_hit);
          check_field("hit_start", want.hit_start, out_hit_start);
          check_field("hit_end", want.hit_end, out_hit_end);
          check_field("partner_found", want.partner_found, out_partner_found);
          check_field("partner_start", want.partner_start, out_partner_start);
          check_field("partner_end", want.partner_end, out_partner_end);
        end
      end
      if (in_valid && in_ready) begin
        case (in_opcode)
          OP_CLEAR: n_spans = 0;
          OP_APPEND: begin
            if (n_spans < TABLE_DEPTH) begin
              span_kind[n_spans] = kind_e_t'(in_token_kind);
              span_lo[n_spans]   = in_token_start;
              span_hi[n_spans]   = in_token_end;
              n_spans++;
            end
          end
          OP_QUERY: expected_matches.push_back(locate_partner(in_cursor_position));
          default: ;
        endcase
      end
    end
    outstanding = expected_matches.size();
  end

endmodule

FILE: tb/tb_top.sv
// testbench top for the bracket pair matcher: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import bpm_pkg::*;

  localparam int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned LIMIT       = 2000000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_opcode;
  logic [KIND_W-1:0] in_token_kind;
  logic [POS_W-1:0]  in_token_start;
  logic [POS_W-1:0]  in_token_end;
  logic [POS_W-1:0]  in_cursor_position;
  logic              out_valid;
  logic              out_ready;
  logic              out_hit;
  logic [POS_W-1:0]  out_hit_start;
  logic [POS_W-1:0]  out_hit_end;
  logic              out_partner_found;
  logic [POS_W-1:0]  out_partner_start;
  logic [POS_W-1:0]  out_partner_end;

  int                fail_count;
  int                outstanding;
  int                snd_idle = 16;
  int                rcv_idle = 70;
  bit                rcv_hold = 1'b0;
  int unsigned       sent_items = 0;
  int unsigned       cycle_count = 0;
  logic [POS_W-1:0]  known_lo[$];
  logic [POS_W-1:0]  known_hi[$];
  event              hold_start;

  bracket_pair_matcher #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_token_kind(in_token_kind), .in_token_start(in_token_start),
    .in_token_end(in_token_end), .in_cursor_position(in_cursor_position),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_hit_start(out_hit_start), .out_hit_end(out_hit_end),
    .out_partner_found(out_partner_found), .out_partner_start(out_partner_start),
    .out_partner_end(out_partner_end)
  );

  bpm_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_token_kind(in_token_kind), .in_token_start(in_token_start),
    .in_token_end(in_token_end), .in_cursor_position(in_cursor_position),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_hit_start(out_hit_start), .out_hit_end(out_hit_end),
    .out_partner_found(out_partner_found), .out_partner_start(out_partner_start),
    .out_partner_end(out_partner_end),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL bracket_pair_matcher");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !rcv_hold && ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    forever begin
      @(hold_start);
      rcv_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rcv_hold = 1'b0;
    end
  end

  task automatic send_word(input logic [1:0] op, input kind_e_t kind,
                           input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
                           input logic [POS_W-1:0] cur);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= op;
    in_token_kind      <= kind;
    in_token_start     <= lo;
    in_token_end       <= hi;
    in_cursor_position <= cur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) sent_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  task automatic do_clear();
    send_word(OP_CLEAR, kind_e_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    known_lo.delete();
    known_hi.delete();
  endtask

  task automatic do_append(input kind_e_t kind, input logic [POS_W-1:0] lo,
                           input logic [POS_W-1:0] hi);
    send_word(OP_APPEND, kind, lo, hi, $urandom);
    known_lo.push_back(lo);
    known_hi.push_back(hi);
  endtask

  task automatic do_query(input logic [POS_W-1:0] cur);
    send_word(OP_QUERY, kind_e_t'($urandom_range(0, 3)), $urandom, $urandom, cur);
  endtask

  task automatic do_ignored();
    send_word(OP_UNUSED, kind_e_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
  endtask

  function automatic kind_e_t random_kind(input bit opener);
    if (opener) return $urandom_range(0, 1) ? KIND_IF : KIND_OPEN;
    return $urandom_range(0, 1) ? KIND_ENDIF : KIND_CLOSE;
  endfunction

  function automatic logic [POS_W-1:0] pick_cursor();
    int unsigned j, last;
    if ((known_lo.size() == 0) || ($urandom_range(0, 9) == 0)) return $urandom;
    j    = $urandom_range(0, known_lo.size() - 1);
    last = known_lo.size() - 1;
    case ($urandom_range(0, 5))
      0: return known_lo[j];
      1: return known_hi[j];
      2: return known_lo[j] - 1;
      3: return known_hi[j] + 1;
      4: return known_lo[j] + $urandom_range(0, known_hi[j] - known_lo[j]);
      default: return $urandom_range(known_lo[0], known_hi[last]);
    endcase
  endfunction

  task automatic append_nest(input int unsigned n, input bit broken,
                             input logic [POS_W-1:0] base);
    logic [POS_W-1:0] pos;
    int unsigned      k, depth, w;
    bit               opener;
    pos   = base;
    depth = 0;
    for (k = 0; k < n; k++) begin
      if (broken) opener = $urandom_range(0, 1);
      else if (depth == 0) opener = 1'b1;
      else if (depth >= n - k) opener = 1'b0;
      else opener = $urandom_range(0, 1);
      if (opener) depth++;
      else if (depth > 0) depth--;
      w = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
      do_append(random_kind(opener), pos, pos + w);
      pos = pos + w + $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) do_query(pick_cursor());
    end
  endtask

  task automatic run_episode();
    int unsigned n, k, style, n_queries;
    style     = $urandom_range(0, 9);
    n         = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    n_queries = $urandom_range(1, 6);
    if ($urandom_range(0, 3) != 0) do_clear();
    if (style == 0) begin
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 5) == 0) do_ignored();
        else do_append(kind_e_t'($urandom_range(0, 3)), $urandom, $urandom);
      end
    end else begin
      append_nest(n, style == 1, ($urandom_range(0, 4) == 0) ?
                  $urandom_range(32'hFFFF_0000, 32'hFFFF_FE00) : $urandom_range(0, 1000));
    end
    for (k = 0; k < n_queries; k++) do_query(pick_cursor());
  endtask

  task automatic fill_table();
    int unsigned k;
    do_clear();
    for (k = 0; k < TABLE_DEPTH + 4; k++) begin
      do_append(random_kind(k < TABLE_DEPTH / 2), 2 * k, 2 * k + 1);
      if (k % 64 == 63) do_query(pick_cursor());
    end
    do_query(0);
    do_query(2 * (TABLE_DEPTH - 1));
    do_query(2 * TABLE_DEPTH);
    for (k = 0; k < 4; k++) do_query(pick_cursor());
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_opcode          = OP_CLEAR;
    in_token_kind      = KIND_OPEN;
    in_token_start     = '0;
    in_token_end       = '0;
    in_cursor_position = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, nesting, fallback on a token end, empty span, extremes
    do_query(0);
    do_ignored();
    do_append(KIND_OPEN, 0, 1);
    do_append(KIND_IF, 2, 4);
    do_append(KIND_ENDIF, 6, 8);
    do_append(KIND_CLOSE, 8, 9);
    do_query(0);
    do_query(3);
    do_query(7);
    do_query(8);
    do_query(1);
    do_query(4);
    do_query(5);
    do_query(9);
    do_append(KIND_OPEN, 9, 9);
    do_query(9);
    do_query(32'hFFFF_FFFF);
    do_clear();
    do_query(8);
    do_append(KIND_ENDIF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    do_query(32'hFFFF_FFFF);
    do_query(32'hFFFF_FFFE);

    // long output stall while queries keep coming
    append_nest(8, 1'b0, 100);
    -> hold_start;
    repeat (4) do_query(pick_cursor());
    drain();

    while (sent_items < 330) run_episode();
    drain();
    snd_idle = 70;
    rcv_idle = 16;
    while (sent_items < 660) run_episode();
    drain();
    snd_idle = 0;
    rcv_idle = 0;
    fill_table();
    while (sent_items < 1050) run_episode();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS bracket_pair_matcher");
    else $display("FAIL bracket_pair_matcher");
    $finish;
  end

endmodule
